### sv/rafb_pkg.sv
package rafb_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int SLOT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = 32;
	localparam int DIV_STEPS   = ADDR_W;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_ALLOC  = 3'd1,
		OP_FREE   = 3'd2,
		OP_GROW   = 3'd3,
		OP_SHRINK = 3'd4,
		OP_QUERY  = 3'd5
	} op_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_FIT   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BAD_TAIL = 3'd3;
	localparam logic [2:0] ST_NOT_FND  = 3'd4;

	// configuration register indexes
	localparam logic REG_POOL_BASE   = 1'b0;
	localparam logic REG_POOL_LENGTH = 1'b1;

	typedef struct packed {
		logic              is_free;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
	} region_t;

endpackage

### sv/range_allocator_first_best_fit_unit.sv
// channel  | handshake             | payload
// in       | in_valid / in_stall   | op, req_size, align_to, use_best_fit, block_addr
// out      | out_valid / out_stall | status, granted_start, tail_free, single_region
// cfg      | cfg_we                | cfg_index, cfg_wdata
// one item at a time: in_stall holds until the result is loaded into the output register
// alloc scans the free stack entry by entry; an aligned candidate also runs the remainder divider
// inserting or deleting a region shifts the region memory and renumbers the free stack
// entry by entry; the single read port of each memory sets the pace
// reset clears only control state, counts and the pool registers; no clearing pass
// a new item is taken while the previous result waits under out_stall
module range_allocator_first_best_fit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] req_size,
	input  logic [31:0] align_to,
	input  logic        use_best_fit,
	input  logic [31:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] granted_start,
	output logic [31:0] tail_free,
	output logic        single_region,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [33:0] {
		S_IDLE    = 34'd1 << 0,
		S_A_RFS   = 34'd1 << 1,
		S_A_RFSW  = 34'd1 << 2,
		S_A_RTW   = 34'd1 << 3,
		S_A_DIV   = 34'd1 << 4,
		S_A_EVAL  = 34'd1 << 5,
		S_A_DONE  = 34'd1 << 6,
		S_A_GAP   = 34'd1 << 7,
		S_A_GAP2  = 34'd1 << 8,
		S_A_FIT   = 34'd1 << 9,
		S_A_SPL   = 34'd1 << 10,
		S_A_SPL2  = 34'd1 << 11,
		S_A_POST  = 34'd1 << 12,
		S_F_RD    = 34'd1 << 13,
		S_F_CHK   = 34'd1 << 14,
		S_T_RD    = 34'd1 << 15,
		S_T_ACT   = 34'd1 << 16,
		S_PB_R0   = 34'd1 << 17,
		S_PB_R1   = 34'd1 << 18,
		S_PB_R2   = 34'd1 << 19,
		S_PB_ACT  = 34'd1 << 20,
		S_PB_D2   = 34'd1 << 21,
		S_E_TUP   = 34'd1 << 22,
		S_E_TUPW  = 34'd1 << 23,
		S_E_TDN   = 34'd1 << 24,
		S_E_TDNW  = 34'd1 << 25,
		S_E_REN   = 34'd1 << 26,
		S_E_RENW  = 34'd1 << 27,
		S_E_FREM  = 34'd1 << 28,
		S_E_FREMW = 34'd1 << 29,
		S_E_PF    = 34'd1 << 30,
		S_E_PFW   = 34'd1 << 31,
		S_FIN     = 34'd1 << 32,
		S_FIN_W   = 34'd1 << 33
	} state_t;

	localparam int SW = rafb_pkg::SLOT_W;
	localparam int CW = rafb_pkg::CNT_W;
	localparam int AW = rafb_pkg::ADDR_W;

	state_t state_q, ret_q;

	logic [AW-1:0] pool_base_q, pool_length_q;
	logic [2:0]    op_q;
	logic [AW-1:0] size_q, align_q, addr_q;
	logic          best_q;
	logic [CW-1:0] count_q, depth_q, i_q, k_q, j_q;
	logic [SW-1:0] ep_q, p_q, g_q, s_q, cslot_q;
	logic          del_q, inc_q, found_q, gapped_q, pfree_q;
	logic [AW-1:0] pstart_q, plen_q, pw_q, cstart_q, clen_q;
	logic [AW-1:0] rem_q, dvd_q, granted_q;
	logic [4:0]    dcnt_q;
	logic [2:0]    status_q;
	rafb_pkg::region_t prev_q, cur_q;

	logic          out_valid_q, single_q;
	logic [2:0]    out_status_q;
	logic [AW-1:0] out_granted_q, out_tail_q;

	// region memory and free stack memory
	rafb_pkg::region_t tbl_mem [rafb_pkg::MAX_REGIONS];
	logic [SW-1:0]     fs_mem  [rafb_pkg::MAX_REGIONS];
	rafb_pkg::region_t rd;
	logic [SW-1:0]     fv;

	logic              t_re, t_we, f_re, f_we;
	logic [SW-1:0]     t_raddr, t_waddr, f_raddr, f_waddr, f_wdata;
	rafb_pkg::region_t t_wdata;

	logic [CW-1:0] cnt_m1, i_m1, i_p1, k_m1;
	logic [SW-1:0] s_m1, s_p1, p_p1;
	logic [AW:0]   div_tmp;
	logic [AW-1:0] div_rem, w_cur;
	logic          fits, nfree, load_out;
	logic [1:0]    need;
	logic          over;

	assign cnt_m1 = count_q - 1'b1;
	assign i_m1   = i_q - 1'b1;
	assign i_p1   = i_q + 1'b1;
	assign k_m1   = k_q - 1'b1;
	assign s_m1   = s_q - 1'b1;
	assign s_p1   = s_q + 1'b1;
	assign p_p1   = p_q + 1'b1;

	// one restoring remainder step per cycle
	assign div_tmp = {rem_q, dvd_q[AW-1]};
	assign div_rem = (div_tmp >= {1'b0, align_q}) ? AW'(div_tmp - {1'b0, align_q})
	                                              : div_tmp[AW-1:0];
	assign w_cur   = (rem_q == '0) ? '0 : align_q - rem_q;
	assign fits    = (clen_q - size_q) >= w_cur;
	assign nfree   = ((CW'(s_q) + 1'b1) < count_q) && rd.is_free;
	assign need    = {1'b0, (pw_q != '0)} + {1'b0, ((plen_q - pw_q) != size_q)};
	assign over    = ({1'b0, count_q} + (CW + 1)'(need)) > (CW + 1)'(rafb_pkg::MAX_REGIONS);
	assign load_out = (state_q == S_FIN_W) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (t_we) tbl_mem[t_waddr] <= t_wdata;
		if (t_re) rd <= tbl_mem[t_raddr];
		if (f_we) fs_mem[f_waddr] <= f_wdata;
		if (f_re) fv <= fs_mem[f_raddr];
	end

	always_comb begin
		t_re = 1'b0; t_raddr = '0;
		t_we = 1'b0; t_waddr = '0; t_wdata = '0;
		f_re = 1'b0; f_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && rafb_pkg::op_t'(op) == rafb_pkg::OP_INIT) begin
					t_we = 1'b1;
					t_wdata = '{is_free: 1'b1, start: pool_base_q, len: pool_length_q};
					f_we = 1'b1;
				end
			end
			S_A_RFS: begin
				f_re = k_q < depth_q;
				f_raddr = k_q[SW-1:0];
			end
			S_A_RFSW: begin
				t_re = CW'(fv) < count_q;
				t_raddr = fv;
			end
			S_A_GAP: begin
				t_we = 1'b1; t_waddr = p_q;
				t_wdata = '{is_free: 1'b0, start: pstart_q, len: pw_q};
			end
			S_A_GAP2: begin
				t_we = 1'b1; t_waddr = p_p1;
				t_wdata = '{is_free: 1'b1, start: pstart_q + pw_q, len: plen_q - pw_q};
			end
			S_A_FIT: begin
				t_we = plen_q == size_q; t_waddr = p_q;
				t_wdata = '{is_free: 1'b0, start: pstart_q, len: plen_q};
			end
			S_A_SPL: begin
				t_we = 1'b1; t_waddr = p_q;
				t_wdata = '{is_free: 1'b0, start: pstart_q, len: size_q};
			end
			S_A_SPL2: begin
				t_we = 1'b1; t_waddr = p_p1;
				t_wdata = '{is_free: 1'b1, start: pstart_q + size_q, len: plen_q - size_q};
			end
			S_F_RD: begin
				t_re = i_q < count_q;
				t_raddr = i_q[SW-1:0];
			end
			S_T_RD, S_FIN: begin
				t_re = count_q != '0;
				t_raddr = cnt_m1[SW-1:0];
			end
			S_T_ACT: begin
				if (op_q == rafb_pkg::OP_GROW) begin
					if (rd.is_free) begin
						t_we = 1'b1; t_waddr = cnt_m1[SW-1:0];
						t_wdata = '{is_free: 1'b1, start: rd.start, len: rd.len + size_q};
					end else if (count_q != rafb_pkg::MAX_CNT) begin
						t_we = 1'b1; t_waddr = count_q[SW-1:0];
						t_wdata = '{is_free: 1'b1, start: rd.start + rd.len, len: size_q};
						f_we = 1'b1; f_waddr = depth_q[SW-1:0]; f_wdata = count_q[SW-1:0];
					end
				end else if (rd.is_free && rd.len > size_q) begin
					t_we = 1'b1; t_waddr = cnt_m1[SW-1:0];
					t_wdata = '{is_free: 1'b1, start: rd.start, len: rd.len - size_q};
				end
			end
			S_PB_R0: begin
				t_re = s_q != '0;
				t_raddr = s_m1;
			end
			S_PB_R1: begin
				t_re = 1'b1;
				t_raddr = s_q;
			end
			S_PB_R2: begin
				t_re = (CW'(s_q) + 1'b1) < count_q;
				t_raddr = s_p1;
			end
			S_PB_ACT: begin
				t_we = 1'b1;
				if (pfree_q && nfree) begin
					t_waddr = s_m1;
					t_wdata = '{is_free: 1'b1, start: prev_q.start,
					            len: prev_q.len + cur_q.len + rd.len};
				end else if (pfree_q) begin
					t_waddr = s_m1;
					t_wdata = '{is_free: 1'b1, start: prev_q.start, len: prev_q.len + cur_q.len};
				end else if (nfree) begin
					t_waddr = s_p1;
					t_wdata = '{is_free: 1'b1, start: cur_q.start, len: rd.len + cur_q.len};
				end else begin
					t_waddr = s_q;
					t_wdata = '{is_free: 1'b1, start: cur_q.start, len: cur_q.len};
				end
			end
			S_E_TUP: begin
				t_re = i_q != CW'(ep_q);
				t_raddr = i_m1[SW-1:0];
			end
			S_E_TUPW, S_E_TDNW: begin
				t_we = 1'b1; t_waddr = i_q[SW-1:0]; t_wdata = rd;
			end
			S_E_TDN: begin
				t_re = i_p1 < count_q;
				t_raddr = i_p1[SW-1:0];
			end
			S_E_REN, S_E_FREM: begin
				f_re = k_q < depth_q;
				f_raddr = k_q[SW-1:0];
			end
			S_E_RENW: begin
				f_we = 1'b1; f_waddr = k_q[SW-1:0];
				if (inc_q) f_wdata = (fv >= ep_q) ? fv + 1'b1 : fv;
				else       f_wdata = (fv > ep_q) ? fv - 1'b1 : fv;
			end
			S_E_FREMW: begin
				f_we = fv != ep_q; f_waddr = j_q[SW-1:0]; f_wdata = fv;
			end
			S_E_PF: begin
				if (k_q == '0) begin
					f_we = 1'b1; f_wdata = ep_q;
				end else begin
					f_re = 1'b1; f_raddr = k_m1[SW-1:0];
				end
			end
			S_E_PFW: begin
				f_we = 1'b1; f_waddr = k_q[SW-1:0]; f_wdata = fv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ret_q <= S_FIN;
			pool_base_q <= '0; pool_length_q <= '0;
			count_q <= '0; depth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rafb_pkg::REG_POOL_LENGTH) pool_length_q <= cfg_wdata;
				else                                        pool_base_q   <= cfg_wdata;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op; size_q <= req_size; align_q <= align_to;
						best_q <= use_best_fit; addr_q <= block_addr;
						status_q <= rafb_pkg::ST_OK; granted_q <= '0;
						found_q <= 1'b0; k_q <= '0; i_q <= '0;
						case (rafb_pkg::op_t'(op))
							rafb_pkg::OP_INIT: begin
								count_q <= CW'(1); depth_q <= CW'(1);
								state_q <= S_FIN;
							end
							rafb_pkg::OP_ALLOC:  state_q <= S_A_RFS;
							rafb_pkg::OP_FREE:   state_q <= S_F_RD;
							rafb_pkg::OP_GROW,
							rafb_pkg::OP_SHRINK: state_q <= S_T_RD;
							default:             state_q <= S_FIN;
						endcase
					end
				end
				S_A_RFS: state_q <= (k_q < depth_q) ? S_A_RFSW : S_A_DONE;
				S_A_RFSW: begin
					if (CW'(fv) >= count_q) begin
						k_q <= k_q + 1'b1; state_q <= S_A_RFS;
					end else begin
						cslot_q <= fv; state_q <= S_A_RTW;
					end
				end
				S_A_RTW: begin
					if (rd.len < size_q) begin
						k_q <= k_q + 1'b1; state_q <= S_A_RFS;
					end else begin
						cstart_q <= rd.start; clen_q <= rd.len;
						rem_q <= '0; dvd_q <= rd.start; dcnt_q <= '0;
						state_q <= (align_q == '0) ? S_A_EVAL : S_A_DIV;
					end
				end
				S_A_DIV: begin
					rem_q <= div_rem; dvd_q <= dvd_q << 1; dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'(rafb_pkg::DIV_STEPS - 1)) state_q <= S_A_EVAL;
				end
				S_A_EVAL: begin
					k_q <= k_q + 1'b1;
					// first fit stops at the first candidate that fits, best fit keeps the shortest
					if (fits && (!best_q || !found_q || clen_q < plen_q)) begin
						p_q <= cslot_q; pstart_q <= cstart_q; plen_q <= clen_q;
						pw_q <= w_cur; found_q <= 1'b1;
					end
					state_q <= (fits && !best_q) ? S_A_DONE : S_A_RFS;
				end
				S_A_DONE: begin
					if (!found_q) begin
						status_q <= rafb_pkg::ST_NO_FIT; state_q <= S_FIN;
					end else if (over) begin
						status_q <= rafb_pkg::ST_FULL; state_q <= S_FIN;
					end else if (pw_q != '0) begin
						gapped_q <= 1'b1; ep_q <= p_q; i_q <= count_q;
						ret_q <= S_A_GAP; state_q <= S_E_TUP;
					end else begin
						gapped_q <= 1'b0; state_q <= S_A_FIT;
					end
				end
				S_A_GAP: state_q <= S_A_GAP2;
				S_A_GAP2: begin
					g_q <= p_q; p_q <= p_p1;
					pstart_q <= pstart_q + pw_q; plen_q <= plen_q - pw_q;
					state_q <= S_A_FIT;
				end
				S_A_FIT: begin
					granted_q <= pstart_q; ep_q <= p_q;
					if (plen_q == size_q) begin
						k_q <= '0; j_q <= '0; del_q <= 1'b0;
						ret_q <= S_A_POST; state_q <= S_E_FREM;
					end else begin
						i_q <= count_q; ret_q <= S_A_SPL; state_q <= S_E_TUP;
					end
				end
				S_A_SPL:  state_q <= S_A_SPL2;
				S_A_SPL2: state_q <= S_A_POST;
				S_A_POST: begin
					if (gapped_q) begin
						s_q <= g_q; state_q <= S_PB_R0;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_F_RD: begin
					if (i_q >= count_q) begin
						status_q <= rafb_pkg::ST_NOT_FND; state_q <= S_FIN;
					end else begin
						state_q <= S_F_CHK;
					end
				end
				S_F_CHK: begin
					if (!rd.is_free && rd.start == addr_q) begin
						s_q <= i_q[SW-1:0]; state_q <= S_PB_R0;
					end else begin
						i_q <= i_p1; state_q <= S_F_RD;
					end
				end
				S_T_RD: begin
					if (count_q == '0) begin
						status_q <= rafb_pkg::ST_BAD_TAIL; state_q <= S_FIN;
					end else begin
						state_q <= S_T_ACT;
					end
				end
				S_T_ACT: begin
					if (op_q == rafb_pkg::OP_GROW) begin
						if (!rd.is_free) begin
							if (count_q == rafb_pkg::MAX_CNT) begin
								status_q <= rafb_pkg::ST_FULL;
							end else begin
								count_q <= count_q + 1'b1; depth_q <= depth_q + 1'b1;
							end
						end
					end else if (!rd.is_free || rd.len <= size_q) begin
						status_q <= rafb_pkg::ST_BAD_TAIL;
					end
					state_q <= S_FIN;
				end
				S_PB_R0: state_q <= S_PB_R1;
				S_PB_R1: begin
					prev_q <= rd; pfree_q <= (s_q != '0) && rd.is_free;
					state_q <= S_PB_R2;
				end
				S_PB_R2: begin
					cur_q <= rd; state_q <= S_PB_ACT;
				end
				S_PB_ACT: begin
					j_q <= '0; del_q <= 1'b1;
					if (pfree_q && nfree) begin
						k_q <= '0; ep_q <= s_p1; ret_q <= S_PB_D2; state_q <= S_E_FREM;
					end else if (pfree_q || nfree) begin
						k_q <= '0; ep_q <= s_q; ret_q <= S_FIN; state_q <= S_E_FREM;
					end else begin
						ep_q <= s_q; k_q <= depth_q; ret_q <= S_FIN; state_q <= S_E_PF;
					end
				end
				S_PB_D2: begin
					ep_q <= s_q; k_q <= '0; j_q <= '0; del_q <= 1'b1;
					ret_q <= S_FIN; state_q <= S_E_FREM;
				end
				S_E_TUP: begin
					if (i_q == CW'(ep_q)) begin
						k_q <= '0; inc_q <= 1'b1; state_q <= S_E_REN;
					end else begin
						state_q <= S_E_TUPW;
					end
				end
				S_E_TUPW: begin
					i_q <= i_m1; state_q <= S_E_TUP;
				end
				S_E_TDN: begin
					if (i_p1 >= count_q) begin
						k_q <= '0; inc_q <= 1'b0; state_q <= S_E_REN;
					end else begin
						state_q <= S_E_TDNW;
					end
				end
				S_E_TDNW: begin
					i_q <= i_p1; state_q <= S_E_TDN;
				end
				S_E_REN: begin
					if (k_q >= depth_q) begin
						count_q <= inc_q ? count_q + 1'b1 : cnt_m1;
						state_q <= ret_q;
					end else begin
						state_q <= S_E_RENW;
					end
				end
				S_E_RENW: begin
					k_q <= k_q + 1'b1; state_q <= S_E_REN;
				end
				S_E_FREM: begin
					if (k_q >= depth_q) begin
						depth_q <= j_q;
						if (del_q) begin
							i_q <= CW'(ep_q); state_q <= S_E_TDN;
						end else begin
							state_q <= ret_q;
						end
					end else begin
						state_q <= S_E_FREMW;
					end
				end
				S_E_FREMW: begin
					if (fv != ep_q) j_q <= j_q + 1'b1;
					k_q <= k_q + 1'b1; state_q <= S_E_FREM;
				end
				S_E_PF: begin
					if (k_q == '0) begin
						depth_q <= depth_q + 1'b1; state_q <= ret_q;
					end else begin
						state_q <= S_E_PFW;
					end
				end
				S_E_PFW: begin
					k_q <= k_m1; state_q <= S_E_PF;
				end
				S_FIN: state_q <= S_FIN_W;
				S_FIN_W: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q  <= status_q;
			out_granted_q <= (status_q == rafb_pkg::ST_OK) ? granted_q : '0;
			out_tail_q    <= (count_q != '0 && rd.is_free) ? rd.len : '0;
			single_q      <= count_q == CW'(1);
		end
	end

	assign in_stall      = state_q != S_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_start = out_granted_q;
	assign tail_free     = out_tail_q;
	assign single_region = single_q;

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n) depth_q <= count_q)
		else $error("free stack deeper than region table");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rafb_pkg::MAX_CNT)
		else $error("region count overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted item did not start");
	a_load: assert property (@(posedge clk) disable iff (!arst_n) load_out |=> out_valid_q)
		else $error("result lost");
`endif

endmodule

### test/testbench.sv
module testbench;

	localparam int          LIMIT       = 20000000;
	localparam int          HOLD_CYCLES = 600;
	localparam logic [2:0]  OP_SPARE_A  = 3'd6;
	localparam logic [2:0]  OP_SPARE_B  = 3'd7;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] granted;
		logic [31:0] tail;
		logic        single;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = rafb_pkg::OP_QUERY;
	logic [31:0] req_size = '0;
	logic [31:0] align_to = '0;
	logic        use_best_fit = 1'b0;
	logic [31:0] block_addr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] granted_start;
	logic [31:0] tail_free;
	logic        single_region;
	logic        cfg_we = 1'b0;
	logic        cfg_index = rafb_pkg::REG_POOL_BASE;
	logic [31:0] cfg_wdata = '0;

	// shadow of the region table
	logic [31:0] rg_start [rafb_pkg::MAX_REGIONS];
	logic [31:0] rg_len [rafb_pkg::MAX_REGIONS];
	bit          rg_free [rafb_pkg::MAX_REGIONS];
	int          free_list [rafb_pkg::MAX_REGIONS];
	int          free_cnt = 0;
	int          rg_cnt = 0;
	logic [31:0] pool_base_q = '0;
	logic [31:0] pool_len_q = '0;

	alloc_result_t results_due[$];
	logic [31:0]   live_blocks[$];
	int            errors = 0;
	int            cycles = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	bit            hold_req = 0;
	bit            hold_done = 0;
	int            hold_cnt = 0;

	range_allocator_first_best_fit_unit uut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= HOLD_CYCLES)
				hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t unexpected item: status %0d granted %h tail %h single %0d",
					$time, status, granted_start, tail_free, single_region);
				errors++;
			end else begin
				exp_r = results_due.pop_front();
				if (status !== exp_r.st) begin
					$display("%0t status: expected %0d actual %0d", $time, exp_r.st, status);
					errors++;
				end
				if (granted_start !== exp_r.granted) begin
					$display("%0t granted_start: expected %h actual %h", $time,
						exp_r.granted, granted_start);
					errors++;
				end
				if (tail_free !== exp_r.tail) begin
					$display("%0t tail_free: expected %h actual %h", $time,
						exp_r.tail, tail_free);
					errors++;
				end
				if (single_region !== exp_r.single) begin
					$display("%0t single_region: expected %0d actual %0d", $time,
						exp_r.single, single_region);
					errors++;
				end
			end
		end
	end

	function automatic void free_list_drop(int slot);
		int j;
		j = 0;
		for (int i = 0; i < free_cnt; i++)
			if (free_list[i] != slot) begin
				free_list[j] = free_list[i];
				j++;
			end
		free_cnt = j;
	endfunction

	function automatic void free_list_push(int slot, bit at_top);
		if (free_cnt >= rafb_pkg::MAX_REGIONS)
			return;
		if (at_top) begin
			for (int i = free_cnt; i > 0; i--)
				free_list[i] = free_list[i-1];
			free_list[0] = slot;
		end else begin
			free_list[free_cnt] = slot;
		end
		free_cnt++;
	endfunction

	function automatic void open_slot(int p);
		for (int i = rg_cnt; i > p; i--) begin
			rg_start[i] = rg_start[i-1];
			rg_len[i]   = rg_len[i-1];
			rg_free[i]  = rg_free[i-1];
		end
		for (int i = 0; i < free_cnt; i++)
			if (free_list[i] >= p)
				free_list[i]++;
		rg_cnt++;
	endfunction

	function automatic void close_slot(int p);
		free_list_drop(p);
		for (int i = p; i + 1 < rg_cnt; i++) begin
			rg_start[i] = rg_start[i+1];
			rg_len[i]   = rg_len[i+1];
			rg_free[i]  = rg_free[i+1];
		end
		for (int i = 0; i < free_cnt; i++)
			if (free_list[i] > p)
				free_list[i]--;
		rg_cnt--;
		rg_free[rg_cnt] = 0;
	endfunction

	// release a region and merge with free neighbours
	function automatic void release_region(int s);
		bit into_prev, merged;
		into_prev = 0;
		merged = 0;
		if (s > 0 && rg_free[s-1]) begin
			rg_len[s-1] = rg_len[s-1] + rg_len[s];
			into_prev = 1;
			merged = 1;
		end
		if (s + 1 < rg_cnt && rg_free[s+1]) begin
			if (into_prev) begin
				rg_len[s-1] = rg_len[s-1] + rg_len[s+1];
				close_slot(s + 1);
			end else begin
				rg_len[s+1] = rg_len[s+1] + rg_len[s];
				rg_start[s+1] = rg_start[s];
				merged = 1;
			end
		end
		if (!merged) begin
			rg_free[s] = 1;
			free_list_push(s, 1);
		end else begin
			close_slot(s);
		end
	endfunction

	function automatic logic [2:0] place_block(logic [31:0] size, logic [31:0] align,
			bit best, output logic [31:0] granted);
		int          p, g, e, needed;
		bit          found;
		logic [31:0] best_len, w, gap;
		p = 0;
		g = 0;
		found = 0;
		best_len = '0;
		granted = '0;
		for (int i = 0; i < free_cnt; i++) begin
			e = free_list[i];
			if (e >= rg_cnt || rg_len[e] < size)
				continue;
			w = '0;
			if (align != 0 && rg_start[e] % align != 0)
				w = align - rg_start[e] % align;
			if (rg_len[e] - size >= w) begin
				if (!best) begin
					p = e;
					found = 1;
					break;
				end
				if (!found || rg_len[e] < best_len) begin
					p = e;
					best_len = rg_len[e];
					found = 1;
				end
			end
		end
		if (!found)
			return rafb_pkg::ST_NO_FIT;
		gap = '0;
		if (align != 0 && rg_start[p] % align != 0)
			gap = align - rg_start[p] % align;
		needed = (gap != 0) + (rg_len[p] - gap != size);
		if (rg_cnt + needed > rafb_pkg::MAX_REGIONS)
			return rafb_pkg::ST_FULL;
		if (gap != 0) begin
			open_slot(p);
			rg_start[p] = rg_start[p+1];
			rg_len[p] = gap;
			rg_free[p] = 0;
			g = p;
			p = p + 1;
			rg_start[p] = rg_start[p] + gap;
			rg_len[p] = rg_len[p] - gap;
		end
		if (rg_len[p] == size) begin
			free_list_drop(p);
			rg_free[p] = 0;
		end else begin
			open_slot(p);
			rg_start[p] = rg_start[p+1];
			rg_len[p] = size;
			rg_free[p] = 0;
			rg_start[p+1] = rg_start[p+1] + size;
			rg_len[p+1] = rg_len[p+1] - size;
		end
		granted = rg_start[p];
		if (gap != 0)
			release_region(g);
		return rafb_pkg::ST_OK;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [2:0] o, logic [31:0] size,
			logic [31:0] align, bit best, logic [31:0] addr);
		alloc_result_t r;
		logic [31:0]   gr;
		int            t;
		r.st = rafb_pkg::ST_OK;
		gr = '0;
		case (o)
			rafb_pkg::OP_INIT: begin
				for (int i = 0; i < rafb_pkg::MAX_REGIONS; i++)
					rg_free[i] = 0;
				free_cnt = 0;
				rg_cnt = 1;
				rg_start[0] = pool_base_q;
				rg_len[0] = pool_len_q;
				rg_free[0] = 1;
				free_list_push(0, 0);
			end
			rafb_pkg::OP_ALLOC: r.st = place_block(size, align, best, gr);
			rafb_pkg::OP_FREE: begin
				r.st = rafb_pkg::ST_NOT_FND;
				for (int i = 0; i < rg_cnt; i++)
					if (!rg_free[i] && rg_start[i] == addr) begin
						release_region(i);
						r.st = rafb_pkg::ST_OK;
						break;
					end
			end
			rafb_pkg::OP_GROW: begin
				t = rg_cnt - 1;
				if (rg_cnt == 0) begin
					r.st = rafb_pkg::ST_BAD_TAIL;
				end else if (rg_free[t]) begin
					rg_len[t] = rg_len[t] + size;
				end else if (rg_cnt >= rafb_pkg::MAX_REGIONS) begin
					r.st = rafb_pkg::ST_FULL;
				end else begin
					open_slot(rg_cnt);
					rg_start[t+1] = rg_start[t] + rg_len[t];
					rg_len[t+1] = size;
					rg_free[t+1] = 1;
					free_list_push(t + 1, 0);
				end
			end
			rafb_pkg::OP_SHRINK: begin
				t = rg_cnt - 1;
				if (rg_cnt == 0 || !rg_free[t] || rg_len[t] <= size)
					r.st = rafb_pkg::ST_BAD_TAIL;
				else
					rg_len[t] = rg_len[t] - size;
			end
			default: ;
		endcase
		r.granted = (r.st == rafb_pkg::ST_OK) ? gr : '0;
		r.tail = (rg_cnt > 0 && rg_free[rg_cnt-1]) ? rg_len[rg_cnt-1] : '0;
		r.single = (rg_cnt == 1);
		return r;
	endfunction

	task automatic send_item(logic [2:0] o, logic [31:0] size, logic [31:0] align,
			bit best, logic [31:0] addr);
		alloc_result_t r;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		req_size <= size;
		align_to <= align;
		use_best_fit <= best;
		block_addr <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_alloc(o, size, align, best, addr);
		results_due.push_back(r);
		if (o == rafb_pkg::OP_INIT)
			live_blocks.delete();
		if (o == rafb_pkg::OP_ALLOC && r.st == rafb_pkg::ST_OK)
			live_blocks.push_back(r.granted);
		if (o == rafb_pkg::OP_FREE && r.st == rafb_pkg::ST_OK)
			foreach (live_blocks[i])
				if (live_blocks[i] == addr) begin
					live_blocks.delete(i);
					break;
				end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pool(logic [31:0] base, logic [31:0] len);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= rafb_pkg::REG_POOL_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= rafb_pkg::REG_POOL_LENGTH;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_base_q = base;
		pool_len_q = len;
	endtask

	task automatic test_empty_table();
		send_item(rafb_pkg::OP_ALLOC, 32'd4, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_GROW, 32'd8, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_SHRINK, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_SPARE_A, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(OP_SPARE_B, 32'd1, 32'd1, 1'b1, 32'd1);
	endtask

	task automatic test_directed();
		write_pool(32'd100, 32'd1000);
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_ALLOC, 32'd10, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_ALLOC, 32'd20, 32'd64, 1'b0, 32'd0);    // gap released
		send_item(rafb_pkg::OP_ALLOC, 32'd0, 32'd0, 1'b0, 32'd0);      // zero-length blocks
		send_item(rafb_pkg::OP_ALLOC, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd148);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd100);
		send_item(rafb_pkg::OP_ALLOC, 32'd18, 32'd0, 1'b1, 32'd0);     // best fit, exact
		send_item(rafb_pkg::OP_ALLOC, 32'd5, 32'd7, 1'b1, 32'd0);
		send_item(rafb_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd12345);
		send_item(rafb_pkg::OP_SHRINK, 32'd2000, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_SHRINK, 32'd100, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_GROW, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);        // rebuild
		send_item(rafb_pkg::OP_ALLOC, 32'd1000, 32'd0, 1'b0, 32'd0);   // whole pool
		send_item(rafb_pkg::OP_GROW, 32'd16, 32'd0, 1'b0, 32'd0);       // used tail
		send_item(rafb_pkg::OP_SHRINK, 32'd16, 32'd0, 1'b0, 32'd0);     // equal: refused
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd100);
		send_item(rafb_pkg::OP_ALLOC, 32'd4, 32'hFFFF_FFFF, 1'b1, 32'd0);
		write_pool(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_ALLOC, 32'h20, 32'h10, 1'b0, 32'd0);   // wraps
		send_item(rafb_pkg::OP_QUERY, 32'd0, 32'd0, 1'b0, 32'd0);
	endtask

	task automatic test_table_full();
		write_pool(32'd0, 32'd64);
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		repeat (64)
			send_item(rafb_pkg::OP_ALLOC, 32'd1, 32'd0, $urandom_range(1), 32'd0);
		send_item(rafb_pkg::OP_GROW, 32'd5, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd63);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd20);
		send_item(rafb_pkg::OP_ALLOC, 32'd0, 32'd3, 1'b0, 32'd0);      // no room for gap
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd21);
		send_item(rafb_pkg::OP_FREE, 32'd0, 32'd0, 1'b0, 32'd19);
	endtask

	task automatic random_items(int n);
		int          r, sel;
		logic [31:0] size, align, addr;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			size = (r < 70) ? $urandom_range(0, 64) :
				(r < 92) ? $urandom_range(0, 600) : $urandom;
			r = $urandom_range(99);
			align = (r < 50) ? 32'd0 : (r < 80) ? (32'd1 << $urandom_range(0, 6)) :
				(r < 95) ? $urandom_range(1, 100) : $urandom;
			addr = $urandom;
			if (live_blocks.size() != 0 && $urandom_range(99) < 85)
				addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
			sel = $urandom_range(99);
			if (sel < 42)
				send_item(rafb_pkg::OP_ALLOC, size, align, $urandom_range(1), addr);
			else if (sel < 75)
				send_item(rafb_pkg::OP_FREE, size, align, $urandom_range(1), addr);
			else if (sel < 84)
				send_item(rafb_pkg::OP_GROW, size, align, $urandom_range(1), addr);
			else if (sel < 93)
				send_item(rafb_pkg::OP_SHRINK, size, align, $urandom_range(1), addr);
			else if (sel < 96)
				send_item(rafb_pkg::OP_INIT, size, align, $urandom_range(1), addr);
			else
				send_item(3'($urandom_range(5, 7)), size, align, $urandom_range(1), addr);
		end
	endtask

	task automatic test_random();
		write_pool(32'd0, 32'd2000);
		idle_pct = 0;
		stall_pct = 0;
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		random_items(200);
		write_pool($urandom, 32'd3000);
		idle_pct = 77;
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		random_items(200);
		write_pool(32'hFFFF_F000, 32'h2000);
		idle_pct = 0;
		stall_pct = 77;
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		random_items(200);
		write_pool($urandom, $urandom);
		idle_pct = 29;
		stall_pct = 29;
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		random_items(50);
	endtask

	task automatic test_back_pressure();
		write_pool(32'd0, 32'd0);
		idle_pct = 0;
		stall_pct = 0;
		send_item(rafb_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 32'd0);
		send_item(rafb_pkg::OP_GROW, 32'd500, 32'd0, 1'b0, 32'd0);
		hold_req = 1;
		random_items(30);
		wait_drained();
		random_items(10);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed();
		test_table_full();
		test_random();
		test_back_pressure();
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
